/* src/refcounted_dedup_hash_table_defines.svh */
// Assertion macros shared by the checker.
`ifndef REFCOUNTED_DEDUP_HASH_TABLE_DEFINES_SVH
`define REFCOUNTED_DEDUP_HASH_TABLE_DEFINES_SVH

// Check that an antecedent implies a consequent in the next cycle.
`define RDHT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// Check that an antecedent implies a consequent in the same cycle.
`define RDHT_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`endif

/* src/rdht_pkg.sv */
package rdht_pkg;

  localparam int unsigned BucketBitsDef = 10;
  localparam int unsigned WaysDef       = 4;
  localparam int unsigned CountBitsDef  = 32;
  localparam int unsigned KeyWords      = 4;
  localparam int unsigned WordBits      = 64;
  localparam int unsigned KeyBits       = KeyWords * WordBits;
  localparam int unsigned IndexBits     = 24;
  localparam int unsigned OutCountBits  = 32;

  typedef enum logic [1:0] {
    REQ_INSERT = 2'd0,
    REQ_INC    = 2'd1,
    REQ_DEC    = 2'd2,
    REQ_GET    = 2'd3
  } req_e;

  typedef enum logic [1:0] {
    ST_HIT      = 2'd0,
    ST_NOTFOUND = 2'd1,
    ST_INSERTED = 2'd2,
    ST_FULL     = 2'd3
  } status_e;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [63:0] key_word0;
    logic [63:0] key_word1;
    logic [63:0] key_word2;
    logic [63:0] key_word3;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] ref_count;
    logic [23:0] bucket_index;
  } rsp_t;

  // Controller to datapath commands.
  typedef struct packed {
    logic clear;   // clear one valid row, advance the clear address
    logic load;    // capture request, start bucket read
    logic update;  // evaluate and write back, capture response
  } cmd_t;

  function automatic logic [IndexBits-1:0] parity_index(input logic [KeyBits-1:0] key);
    logic [IndexBits-1:0] idx;
    int unsigned k;
    logic [3:0] nib;
    idx = '0;
    k = 0;
    for (int unsigned b = 0; b < 32; b++) begin
      if ((b % 4) != 3) begin
        nib = key[KeyBits-1-8*b -: 4];
        idx[IndexBits-1-k] = ~^nib;
        k++;
      end
    end
    return idx;
  endfunction

endpackage

/* src/rdht_ctrl.sv */
module rdht_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  input  logic              clr_done_i,
  output rdht_pkg::cmd_t    cmd_o
);
  import rdht_pkg::*;

  typedef enum logic [3:0] {
    S_CLEAR = 4'b0001,
    S_IDLE  = 4'b0010,
    S_EVAL  = 4'b0100,
    S_RESP  = 4'b1000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d     = state_q;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    cmd_o       = '0;
    case (state_q)
      S_CLEAR: begin
        cmd_o.clear = 1'b1;
        if (clr_done_i) state_d = S_IDLE;
      end
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_EVAL;
        end
      end
      S_EVAL: begin
        cmd_o.update = 1'b1;
        state_d      = S_RESP;
      end
      S_RESP: begin
        out_valid_o = 1'b1;
        if (out_ready_i) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= S_CLEAR;
    else         state_q <= state_d;
  end
endmodule

/* src/rdht_datapath.sv */
module rdht_datapath #(
  parameter int unsigned BucketBits = rdht_pkg::BucketBitsDef,
  parameter int unsigned Ways       = rdht_pkg::WaysDef,
  parameter int unsigned CountBits  = rdht_pkg::CountBitsDef
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  rdht_pkg::cmd_t cmd_i,
  input  rdht_pkg::req_t req_i,
  output logic           clr_done_o,
  output rdht_pkg::rsp_t rsp_o
);
  import rdht_pkg::*;

  localparam int unsigned Buckets = 1 << BucketBits;
  localparam int unsigned WayBits = (Ways > 1) ? $clog2(Ways) : 1;
  localparam logic [CountBits-1:0] CountMax = '1;

  // One memory row per bucket holds all ways.
  logic [Ways*KeyBits-1:0]   key_mem [Buckets];
  logic [Ways*CountBits-1:0] cnt_mem [Buckets];
  logic [Ways-1:0]           valid_mem [Buckets];

  logic [KeyBits-1:0]         key_q;
  logic [1:0]                 req_q;
  logic [IndexBits-1:0]       idx_q;
  logic [BucketBits-1:0]      bkt_q;
  logic [Ways*KeyBits-1:0]    keys_rd_q;
  logic [Ways*CountBits-1:0]  cnts_rd_q;
  logic [Ways-1:0]            vld_rd_q;
  logic [BucketBits-1:0]      clr_addr_q, clr_addr_d;

  logic [KeyBits-1:0]    key_in;
  logic [IndexBits-1:0]  idx_in;
  logic [BucketBits-1:0] bkt_in;

  assign key_in = {req_i.key_word0, req_i.key_word1, req_i.key_word2, req_i.key_word3};
  assign idx_in = parity_index(key_in);
  assign bkt_in = idx_in[BucketBits-1:0];

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      key_q     <= key_in;
      req_q     <= req_i.req_type;
      idx_q     <= idx_in;
      bkt_q     <= bkt_in;
      keys_rd_q <= key_mem[bkt_in];
      cnts_rd_q <= cnt_mem[bkt_in];
    end
  end

  // Compare all ways, pick first hit and first free way.
  logic [Ways-1:0]          hit_vec;
  logic                     hit, has_free;
  logic [WayBits-1:0]       hit_way, free_way;
  logic [CountBits-1:0]     cnt_sel, cnt_new;
  logic [1:0]               st;
  logic                     wr_cnt, wr_key, clr_vld;
  logic [WayBits-1:0]       wr_way;

  always_comb begin
    hit = 1'b0; has_free = 1'b0; hit_way = '0; free_way = '0;
    for (int unsigned w = 0; w < Ways; w++) begin
      hit_vec[w] = vld_rd_q[w] && (keys_rd_q[w*KeyBits +: KeyBits] == key_q);
      if (hit_vec[w] && !hit) begin
        hit = 1'b1; hit_way = WayBits'(w);
      end
      if (!vld_rd_q[w] && !has_free) begin
        has_free = 1'b1; free_way = WayBits'(w);
      end
    end
    cnt_sel = cnts_rd_q[hit_way*CountBits +: CountBits];
    cnt_new = '0; st = ST_NOTFOUND; wr_cnt = 1'b0; wr_key = 1'b0; clr_vld = 1'b0;
    wr_way = hit_way;
    if (hit) begin
      st = ST_HIT;
      case (req_q)
        REQ_INSERT, REQ_INC: begin
          cnt_new = (cnt_sel == CountMax) ? cnt_sel : cnt_sel + 1'b1;
          wr_cnt  = 1'b1;
        end
        REQ_DEC: begin
          if (cnt_sel <= CountBits'(1)) begin
            clr_vld = 1'b1;
          end else begin
            cnt_new = cnt_sel - 1'b1;
            wr_cnt  = 1'b1;
          end
        end
        default: cnt_new = cnt_sel;
      endcase
    end else if (req_q == REQ_INSERT) begin
      if (has_free) begin
        st = ST_INSERTED; cnt_new = CountBits'(1);
        wr_cnt = 1'b1; wr_key = 1'b1; wr_way = free_way;
      end else begin
        st = ST_FULL;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.update) begin
      if (wr_cnt) cnt_mem[bkt_q][wr_way*CountBits +: CountBits] <= cnt_new;
      if (wr_key) key_mem[bkt_q][wr_way*KeyBits +: KeyBits] <= key_q;
      rsp_o.status       <= st;
      rsp_o.ref_count    <= OutCountBits'(cnt_new);
      rsp_o.bucket_index <= idx_q;
    end
  end

  // Clear pass after reset: one valid row per cycle, last row ends the pass.
  assign clr_addr_d = clr_addr_q + 1'b1;
  assign clr_done_o = (clr_addr_q == '1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni)          clr_addr_q <= '0;
    else if (cmd_i.clear) clr_addr_q <= clr_addr_d;
  end

  // Valid memory: per-bucket vector read at one address.
  always_ff @(posedge clk_i) begin
    if (cmd_i.clear) valid_mem[clr_addr_q] <= '0;
    if (cmd_i.load)  vld_rd_q <= valid_mem[bkt_in];
    if (cmd_i.update) begin
      if (wr_key)  valid_mem[bkt_q][wr_way] <= 1'b1;
      if (clr_vld) valid_mem[bkt_q][wr_way] <= 1'b0;
    end
  end
endmodule

/* src/refcounted_dedup_hash_table.sv */
// Reference-counted deduplication table.
// Input channel: in_valid_i / in_ready_o with in_data_i (request type and
// four 64-bit checksum words). Output channel: out_valid_o / out_ready_i
// with out_data_o (status, count after the operation, 24-bit bucket index).
// Every request yields exactly one response.
// Accepted requests pass to the evaluate state, where the response is
// registered; it is presented in the response state. Only one request is
// in flight: the bucket read, compare-and-write-back and response complete
// before a new request is taken, so same-bucket accesses never overlap.
// Reset: a clear pass zeroes the valid bits of all 2^BucketBits bucket rows
// (1024 by default), one row per cycle; in_ready_o stays low until the pass
// ends. Key and count memories are not cleared.
// A stalled receiver holds the response; no new request is taken until the
// response transaction completes.
module refcounted_dedup_hash_table #(
  parameter int unsigned BucketBits = rdht_pkg::BucketBitsDef,
  parameter int unsigned Ways       = rdht_pkg::WaysDef,
  parameter int unsigned CountBits  = rdht_pkg::CountBitsDef
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  rdht_pkg::req_t in_data_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output rdht_pkg::rsp_t out_data_o
);
  import rdht_pkg::*;

  cmd_t cmd;
  logic clr_done;

  // Sequence clear, load, evaluate, respond.
  rdht_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .out_valid_o, .out_ready_i,
    .clr_done_i(clr_done), .cmd_o(cmd)
  );

  // Hold bucket memories, compare and update.
  rdht_datapath #(.BucketBits(BucketBits), .Ways(Ways), .CountBits(CountBits)) u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .req_i(in_data_i), .clr_done_o(clr_done),
    .rsp_o(out_data_o)
  );
endmodule

/* src/rdht_checker.sv */
`include "refcounted_dedup_hash_table_defines.svh"
module rdht_props (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           in_valid_i,
  input logic           in_ready_o,
  input logic           out_valid_o,
  input logic           out_ready_i,
  input rdht_pkg::rsp_t out_data_o
);
  import rdht_pkg::*;

  `RDHT_ASSERT_NEXT(a_resp_follows, clk_i, rst_ni, in_valid_i && in_ready_o,
    !out_valid_o && !in_ready_o, "response too early")
  `RDHT_ASSERT_NOW(a_no_overlap, clk_i, rst_ni, out_valid_o, !in_ready_o,
    "input taken with response pending")
  `RDHT_ASSERT_NOW(a_full_zero, clk_i, rst_ni, out_valid_o && out_data_o.status == ST_FULL,
    out_data_o.ref_count == '0, "full with nonzero count")
  `RDHT_ASSERT_NEXT(a_hold, clk_i, rst_ni, out_valid_o && !out_ready_i,
    out_valid_o && $stable(out_data_o), "stalled response changed")
endmodule

bind refcounted_dedup_hash_table rdht_props u_chk (
  .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .out_valid_o, .out_ready_i, .out_data_o
);
